// ===== hdl/tad_pkg.sv =====
// Package for the threshold alarm core: register indexes, trigger and sticky bit positions,
// and the control and result structs shared across the core's modules.
// No dependencies.
`default_nettype none

package tad_pkg;

   localparam int CSR_INDEX_WIDTH        = 3;
   localparam int DEBOUNCE_SAMPLES_WIDTH = 8;
   localparam int TRIGGER_MASK_WIDTH     = 4;
   localparam int STICKY_WIDTH           = 4;

   localparam logic [DEBOUNCE_SAMPLES_WIDTH-1:0] DEBOUNCE_SAMPLES_RESET = 8'd2;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_HIGH_LIMIT       = 3'd0,
      CSR_LOW_LIMIT        = 3'd1,
      CSR_DEADBAND         = 3'd2,
      CSR_DEBOUNCE_SAMPLES = 3'd3,
      CSR_TRIGGER_MASK     = 3'd4,
      CSR_HIGH_ENABLED     = 3'd5,
      CSR_LOW_ENABLED      = 3'd6
   } csr_index_type;

   // trigger mask bits
   localparam int TRIG_EXIT_LOW   = 0;
   localparam int TRIG_ENTER_LOW  = 1;
   localparam int TRIG_EXIT_HIGH  = 2;
   localparam int TRIG_ENTER_HIGH = 3;

   // sticky bits
   localparam int STICKY_ENTER_HIGH = 0;
   localparam int STICKY_EXIT_HIGH  = 1;
   localparam int STICKY_ENTER_LOW  = 2;
   localparam int STICKY_EXIT_LOW   = 3;

   typedef struct packed {
      logic [DEBOUNCE_SAMPLES_WIDTH-1:0] debounce_samples;
      logic [TRIGGER_MASK_WIDTH-1:0]     trigger_mask;
      logic                              high_enabled;
      logic                              low_enabled;
   } tad_ctrl_type;

   typedef struct packed {
      logic                    enter_high;
      logic                    exit_high;
      logic                    enter_low;
      logic                    exit_low;
      logic                    in_high;
      logic                    in_low;
      logic [STICKY_WIDTH-1:0] sticky;
   } tad_result_type;

endpackage

`default_nettype wire

// ===== hdl/tad_intf.sv =====
// Request and response channel interfaces of the threshold alarm core.
// Depends on tad_pkg.
`default_nettype none

interface tad_req_if #(
   parameter int SAMPLE_WIDTH = 32
);
   logic                    valid;
   logic                    ready;
   logic [SAMPLE_WIDTH-1:0] sample;
   logic                    logging_active;

   modport source (output valid, output sample, output logging_active, input ready);
   modport sink   (input valid, input sample, input logging_active, output ready);
endinterface

interface tad_rsp_if;
   import tad_pkg::*;

   logic                    valid;
   logic                    ready;
   logic                    enter_high_event;
   logic                    exit_high_event;
   logic                    enter_low_event;
   logic                    exit_low_event;
   logic                    in_high_alarm;
   logic                    in_low_alarm;
   logic [STICKY_WIDTH-1:0] sticky_events;

   modport source (
      output valid, output enter_high_event, output exit_high_event,
      output enter_low_event, output exit_low_event, output in_high_alarm,
      output in_low_alarm, output sticky_events, input ready
   );
   modport sink (
      input valid, input enter_high_event, input exit_high_event,
      input enter_low_event, input exit_low_event, input in_high_alarm,
      input in_low_alarm, input sticky_events, output ready
   );
endinterface

`default_nettype wire

// ===== hdl/tad_csr_regs.sv =====
// Configuration registers of the threshold alarm core, written through a plain write port.
// Depends on tad_pkg.
`default_nettype none

module tad_csr_regs #(
   parameter int SAMPLE_WIDTH = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [tad_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [SAMPLE_WIDTH-1:0]              csr_wdata,
   output logic [SAMPLE_WIDTH-1:0]              high_limit,
   output logic [SAMPLE_WIDTH-1:0]              low_limit,
   output logic [SAMPLE_WIDTH-2:0]              deadband,
   output tad_pkg::tad_ctrl_type                ctrl
);
   import tad_pkg::*;

   logic [SAMPLE_WIDTH-1:0] high_limit_ff, high_limit_in;
   logic [SAMPLE_WIDTH-1:0] low_limit_ff, low_limit_in;
   logic [SAMPLE_WIDTH-2:0] deadband_ff, deadband_in;
   tad_ctrl_type            ctrl_ff, ctrl_in;

   always_comb begin
      high_limit_in = high_limit_ff;
      low_limit_in  = low_limit_ff;
      deadband_in   = deadband_ff;
      ctrl_in       = ctrl_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_HIGH_LIMIT:       high_limit_in = csr_wdata;
            CSR_LOW_LIMIT:        low_limit_in  = csr_wdata;
            CSR_DEADBAND:         deadband_in   = csr_wdata[SAMPLE_WIDTH-2:0];
            CSR_DEBOUNCE_SAMPLES: begin
               ctrl_in.debounce_samples = DEBOUNCE_SAMPLES_WIDTH'(csr_wdata);
            end
            CSR_TRIGGER_MASK:     ctrl_in.trigger_mask = TRIGGER_MASK_WIDTH'(csr_wdata);
            CSR_HIGH_ENABLED:     ctrl_in.high_enabled = csr_wdata[0];
            CSR_LOW_ENABLED:      ctrl_in.low_enabled  = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         high_limit_ff            <= '0;
         low_limit_ff             <= '0;
         deadband_ff              <= '0;
         ctrl_ff.debounce_samples <= DEBOUNCE_SAMPLES_RESET;
         ctrl_ff.trigger_mask     <= '0;
         ctrl_ff.high_enabled     <= 1'b1;
         ctrl_ff.low_enabled      <= 1'b1;
      end else begin
         high_limit_ff <= high_limit_in;
         low_limit_ff  <= low_limit_in;
         deadband_ff   <= deadband_in;
         ctrl_ff       <= ctrl_in;
      end
   end

   assign high_limit = high_limit_ff;
   assign low_limit  = low_limit_ff;
   assign deadband   = deadband_ff;
   assign ctrl       = ctrl_ff;

endmodule

`default_nettype wire

// ===== hdl/tad_in_stage.sv =====
// Input register of the threshold alarm core: holds one request until the step logic takes it.
// Depends on nothing beyond its ports.
`default_nettype none

module tad_in_stage #(
   parameter int SAMPLE_WIDTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [SAMPLE_WIDTH-1:0] req_sample,
   input  logic                    req_logging,
   input  logic                    advance,
   output logic                    stage_valid,
   output logic [SAMPLE_WIDTH-1:0] stage_sample,
   output logic                    stage_logging
);
   logic                    valid_ff, valid_in;
   logic [SAMPLE_WIDTH-1:0] sample_ff;
   logic                    logging_ff;
   logic                    take;

   assign req_ready = !valid_ff || advance;
   assign take      = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         sample_ff  <= req_sample;
         logging_ff <= req_logging;
      end
   end

   assign stage_valid   = valid_ff;
   assign stage_sample  = sample_ff;
   assign stage_logging = logging_ff;

endmodule

`default_nettype wire

// ===== hdl/tad_alarm_step.sv =====
// Alarm state and one-sample step: hysteresis compares, debounce counters, events, sticky flags.
// Depends on tad_pkg.
`default_nettype none

module tad_alarm_step #(
   parameter int SAMPLE_WIDTH   = 32,
   parameter int DEBOUNCE_WIDTH = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic [SAMPLE_WIDTH-1:0] sample,
   input  logic                    logging,
   input  logic [SAMPLE_WIDTH-1:0] high_limit,
   input  logic [SAMPLE_WIDTH-1:0] low_limit,
   input  logic [SAMPLE_WIDTH-2:0] deadband,
   input  tad_pkg::tad_ctrl_type   ctrl,
   output tad_pkg::tad_result_type result
);
   import tad_pkg::*;

   localparam int EXT_WIDTH = SAMPLE_WIDTH + 1;
   localparam logic [DEBOUNCE_WIDTH-1:0] CNT_ONE = DEBOUNCE_WIDTH'(1);

   logic                      high_alarm_ff, high_alarm_in;
   logic                      low_alarm_ff, low_alarm_in;
   logic [STICKY_WIDTH-1:0]   sticky_ff, sticky_in;
   logic [DEBOUNCE_WIDTH-1:0] high_left_ff, high_left_in;
   logic [DEBOUNCE_WIDTH-1:0] low_left_ff, low_left_in;

   logic signed [EXT_WIDTH-1:0] v_ext, hi_ext, lo_ext, db_ext;
   logic signed [EXT_WIDTH-1:0] hi_plus, hi_minus, lo_plus, lo_minus;
   logic [DEBOUNCE_WIDTH-1:0]   load_val, high_load, low_load;
   logic active;
   logic high_exit, high_keep, high_above, high_enter;
   logic low_exit, low_keep, low_above, low_enter;
   logic ev_enter_high, ev_exit_high, ev_enter_low, ev_exit_low;

   // 33-bit sums so threshold +/- deadband never wraps
   assign v_ext    = $signed({sample[SAMPLE_WIDTH-1], sample});
   assign hi_ext   = $signed({high_limit[SAMPLE_WIDTH-1], high_limit});
   assign lo_ext   = $signed({low_limit[SAMPLE_WIDTH-1], low_limit});
   assign db_ext   = $signed({2'b00, deadband});
   assign hi_plus  = hi_ext + db_ext;
   assign hi_minus = hi_ext - db_ext;
   assign lo_plus  = lo_ext + db_ext;
   assign lo_minus = lo_ext - db_ext;

   assign active   = (ctrl.trigger_mask != '0) && logging;
   assign load_val = DEBOUNCE_WIDTH'(ctrl.debounce_samples);

   always_comb begin
      // exits first
      high_exit  = high_alarm_ff && ctrl.high_enabled && (v_ext < hi_minus);
      high_keep  = high_alarm_ff && ctrl.high_enabled && !high_exit;
      low_exit   = low_alarm_ff && ctrl.low_enabled && (v_ext > lo_plus);
      low_keep   = low_alarm_ff && ctrl.low_enabled && !low_exit;

      // entries with debounce
      high_above = ctrl.high_enabled && (v_ext >= hi_plus);
      low_above  = ctrl.low_enabled && (v_ext <= lo_minus);
      high_load  = (high_left_ff == '0) ? load_val : high_left_ff;
      low_load   = (low_left_ff == '0) ? load_val : low_left_ff;
      high_enter = high_above && !high_keep && (high_load <= CNT_ONE);
      low_enter  = low_above && !low_keep && (low_load <= CNT_ONE);

      high_left_in = '0;
      if (high_above) begin
         if (high_keep) begin
            high_left_in = high_left_ff;
         end else if (high_load > CNT_ONE) begin
            high_left_in = high_load - CNT_ONE;
         end
      end
      low_left_in = '0;
      if (low_above) begin
         if (low_keep) begin
            low_left_in = low_left_ff;
         end else if (low_load > CNT_ONE) begin
            low_left_in = low_load - CNT_ONE;
         end
      end

      ev_enter_high = high_enter && ctrl.trigger_mask[TRIG_ENTER_HIGH];
      ev_exit_high  = high_exit && ctrl.trigger_mask[TRIG_EXIT_HIGH];
      ev_enter_low  = low_enter && ctrl.trigger_mask[TRIG_ENTER_LOW];
      ev_exit_low   = low_exit && ctrl.trigger_mask[TRIG_EXIT_LOW];

      high_alarm_in = high_keep || high_enter;
      low_alarm_in  = low_keep || low_enter;
      sticky_in     = sticky_ff;
      sticky_in[STICKY_ENTER_HIGH] = sticky_ff[STICKY_ENTER_HIGH] || ev_enter_high;
      sticky_in[STICKY_EXIT_HIGH]  = sticky_ff[STICKY_EXIT_HIGH] || ev_exit_high;
      sticky_in[STICKY_ENTER_LOW]  = sticky_ff[STICKY_ENTER_LOW] || ev_enter_low;
      sticky_in[STICKY_EXIT_LOW]   = sticky_ff[STICKY_EXIT_LOW] || ev_exit_low;

      // ignored request: hold everything
      if (!active) begin
         high_alarm_in = high_alarm_ff;
         low_alarm_in  = low_alarm_ff;
         sticky_in     = sticky_ff;
         high_left_in  = high_left_ff;
         low_left_in   = low_left_ff;
         ev_enter_high = 1'b0;
         ev_exit_high  = 1'b0;
         ev_enter_low  = 1'b0;
         ev_exit_low   = 1'b0;
      end

      result.enter_high = ev_enter_high;
      result.exit_high  = ev_exit_high;
      result.enter_low  = ev_enter_low;
      result.exit_low   = ev_exit_low;
      result.in_high    = high_alarm_in;
      result.in_low     = low_alarm_in;
      result.sticky     = sticky_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         high_alarm_ff <= 1'b0;
         low_alarm_ff  <= 1'b0;
         sticky_ff     <= '0;
         high_left_ff  <= '0;
         low_left_ff   <= '0;
      end else if (advance) begin
         high_alarm_ff <= high_alarm_in;
         low_alarm_ff  <= low_alarm_in;
         sticky_ff     <= sticky_in;
         high_left_ff  <= high_left_in;
         low_left_ff   <= low_left_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/tad_out_stage.sv =====
// Result register of the threshold alarm core: holds one response until the sink takes it.
// Depends on tad_pkg.
`default_nettype none

module tad_out_stage (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  tad_pkg::tad_result_type result_in,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output tad_pkg::tad_result_type rsp_result
);
   import tad_pkg::*;

   logic           valid_ff, valid_in;
   tad_result_type result_ff;

   always_comb begin
      valid_in = valid_ff;
      if (advance) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

endmodule

`default_nettype wire

// ===== hdl/threshold_alarm_with_debounce_core.sv =====
// Top level of the dual threshold alarm with hysteresis and debounce.
// Depends on tad_pkg, tad_intf, tad_csr_regs, tad_in_stage, tad_alarm_step, tad_out_stage.
//
// Takes one signed sample per request and returns one response per request, in order.
// Sustained rate is one request per clock while the sink keeps taking responses. A request
// passes the input register, then the result register fed by one pass of compare and counter
// logic, where its response is valid. While a response waits, the input register holds one
// more request and then stalls the input. The user must write configuration through
// csr_wr_en/csr_index/csr_wdata only while the core is idle; the core does not enforce it.
`default_nettype none

module threshold_alarm_with_debounce_core #(
   parameter int SAMPLE_WIDTH   = 32,
   parameter int DEBOUNCE_WIDTH = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   tad_req_if.sink                             req_chan,
   tad_rsp_if.source                           rsp_chan,
   input  logic                                csr_wr_en,
   input  logic [tad_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [SAMPLE_WIDTH-1:0]             csr_wdata
);
   import tad_pkg::*;

   logic [SAMPLE_WIDTH-1:0] high_limit, low_limit;
   logic [SAMPLE_WIDTH-2:0] deadband;
   tad_ctrl_type            ctrl;
   logic                    stage_valid, stage_logging, out_valid, advance;
   logic [SAMPLE_WIDTH-1:0] stage_sample;
   tad_result_type          step_result, out_result;

   assign advance = stage_valid && (!out_valid || rsp_chan.ready);

   tad_csr_regs #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .high_limit (high_limit),
      .low_limit  (low_limit),
      .deadband   (deadband),
      .ctrl       (ctrl)
   );

   tad_in_stage #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_in (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_chan.valid),
      .req_ready     (req_chan.ready),
      .req_sample    (req_chan.sample),
      .req_logging   (req_chan.logging_active),
      .advance       (advance),
      .stage_valid   (stage_valid),
      .stage_sample  (stage_sample),
      .stage_logging (stage_logging)
   );

   tad_alarm_step #(
      .SAMPLE_WIDTH   (SAMPLE_WIDTH),
      .DEBOUNCE_WIDTH (DEBOUNCE_WIDTH)
   ) u_step (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .sample     (stage_sample),
      .logging    (stage_logging),
      .high_limit (high_limit),
      .low_limit  (low_limit),
      .deadband   (deadband),
      .ctrl       (ctrl),
      .result     (step_result)
   );

   tad_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .result_in  (step_result),
      .rsp_ready  (rsp_chan.ready),
      .rsp_valid  (out_valid),
      .rsp_result (out_result)
   );

   assign rsp_chan.valid            = out_valid;
   assign rsp_chan.enter_high_event = out_result.enter_high;
   assign rsp_chan.exit_high_event  = out_result.exit_high;
   assign rsp_chan.enter_low_event  = out_result.enter_low;
   assign rsp_chan.exit_low_event   = out_result.exit_low;
   assign rsp_chan.in_high_alarm    = out_result.in_high;
   assign rsp_chan.in_low_alarm     = out_result.in_low;
   assign rsp_chan.sticky_events    = out_result.sticky;

endmodule

`default_nettype wire

// ===== hdl/tad_checker.sv =====
// Port-level checks of the threshold alarm core, bound to its top level.
// Depends on tad_pkg and threshold_alarm_with_debounce_core.
`default_nettype none

module tad_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic                                 enter_high_event,
   input logic                                 exit_high_event,
   input logic                                 enter_low_event,
   input logic                                 exit_low_event,
   input logic                                 in_high_alarm,
   input logic                                 in_low_alarm,
   input logic [tad_pkg::STICKY_WIDTH-1:0]     sticky_events
);
   import tad_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(sticky_events))
      else $error("response dropped or changed while stalled");

   a_enter_in_alarm: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!enter_high_event || in_high_alarm) && (!enter_low_event || in_low_alarm))
      else $error("enter event without alarm set");

   a_exit_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!exit_high_event || !in_high_alarm) && (!exit_low_event || !in_low_alarm))
      else $error("exit event with alarm still set");

   a_event_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (!enter_high_event || sticky_events[STICKY_ENTER_HIGH]) &&
         (!exit_high_event || sticky_events[STICKY_EXIT_HIGH]) &&
         (!enter_low_event || sticky_events[STICKY_ENTER_LOW]) &&
         (!exit_low_event || sticky_events[STICKY_EXIT_LOW]))
      else $error("event without its sticky bit");

endmodule

bind threshold_alarm_with_debounce_core tad_checker u_tad_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .enter_high_event (rsp_chan.enter_high_event),
   .exit_high_event  (rsp_chan.exit_high_event),
   .enter_low_event  (rsp_chan.enter_low_event),
   .exit_low_event   (rsp_chan.exit_low_event),
   .in_high_alarm    (rsp_chan.in_high_alarm),
   .in_low_alarm     (rsp_chan.in_low_alarm),
   .sticky_events    (rsp_chan.sticky_events)
);

`default_nettype wire

// ===== tb/testbench.sv =====
// Testbench for threshold_alarm_with_debounce_core: drives sample requests and CSR writes,
// predicts each response in a scoreboard class and checks it field by field.
// Depends on tad_pkg, tad_intf and the core's RTL.
`timescale 1ns / 100ps

module testbench;
   import tad_pkg::*;

   localparam int STALL_LIMIT = 2000;

   typedef enum int {
      ABOVE_HIGH,
      BELOW_HIGH,
      BELOW_LOW,
      ABOVE_LOW,
      ON_EDGE,
      ANY_VALUE
   } sample_zone_type;

   class alarm_scoreboard_type;
      logic [31:0]    high_thr;
      logic [31:0]    low_thr;
      logic [30:0]    deadband;
      logic [7:0]     debounce_samples;
      logic [3:0]     trig_mask;
      logic           high_en;
      logic           low_en;
      logic           high_alarm;
      logic           low_alarm;
      logic [3:0]     sticky;
      logic [7:0]     high_left;
      logic [7:0]     low_left;
      tad_result_type expected_q[$];
      int             failures;

      function new();
         high_thr         = '0;
         low_thr          = '0;
         deadband         = '0;
         debounce_samples = DEBOUNCE_SAMPLES_RESET;
         trig_mask        = '0;
         high_en          = 1'b1;
         low_en           = 1'b1;
         high_alarm       = 1'b0;
         low_alarm        = 1'b0;
         sticky           = '0;
         high_left        = '0;
         low_left         = '0;
         failures         = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [31:0] val);
         case (idx)
            CSR_HIGH_LIMIT:       high_thr = val;
            CSR_LOW_LIMIT:        low_thr = val;
            CSR_DEADBAND:         deadband = val[30:0];
            CSR_DEBOUNCE_SAMPLES: debounce_samples = val[7:0];
            CSR_TRIGGER_MASK:     trig_mask = val[3:0];
            CSR_HIGH_ENABLED:     high_en = val[0];
            CSR_LOW_ENABLED:      low_en = val[0];
            default: ;
         endcase
      endfunction

      // true when the run of samples beyond the threshold is long enough to enter
      function bit debounce_done(inout logic [7:0] left);
         if (left == '0) left = debounce_samples;
         if (left > 8'd1) begin
            left = left - 8'd1;
            return 1'b0;
         end
         left = '0;
         return 1'b1;
      endfunction

      function void note_request(logic [31:0] smp, logic logging);
         tad_result_type     r;
         logic signed [33:0] v;
         logic signed [33:0] hi;
         logic signed [33:0] lo;
         logic signed [33:0] db;
         r = '0;
         if (trig_mask != '0 && logging) begin
            v  = {{2{smp[31]}}, smp};
            hi = {{2{high_thr[31]}}, high_thr};
            lo = {{2{low_thr[31]}}, low_thr};
            db = {3'b000, deadband};
            if (high_alarm) begin
               if (!high_en) begin
                  high_alarm = 1'b0;
               end else if (v < hi - db) begin
                  high_alarm = 1'b0;
                  if (trig_mask[TRIG_EXIT_HIGH]) begin
                     r.exit_high = 1'b1;
                     sticky[STICKY_EXIT_HIGH] = 1'b1;
                  end
               end
            end
            if (low_alarm) begin
               if (!low_en) begin
                  low_alarm = 1'b0;
               end else if (v > lo + db) begin
                  low_alarm = 1'b0;
                  if (trig_mask[TRIG_EXIT_LOW]) begin
                     r.exit_low = 1'b1;
                     sticky[STICKY_EXIT_LOW] = 1'b1;
                  end
               end
            end
            if (high_en && v >= hi + db) begin
               if (!high_alarm && debounce_done(high_left)) begin
                  high_alarm = 1'b1;
                  if (trig_mask[TRIG_ENTER_HIGH]) begin
                     r.enter_high = 1'b1;
                     sticky[STICKY_ENTER_HIGH] = 1'b1;
                  end
               end
            end else begin
               high_left = '0;
            end
            if (low_en && v <= lo - db) begin
               if (!low_alarm && debounce_done(low_left)) begin
                  low_alarm = 1'b1;
                  if (trig_mask[TRIG_ENTER_LOW]) begin
                     r.enter_low = 1'b1;
                     sticky[STICKY_ENTER_LOW] = 1'b1;
                  end
               end
            end else begin
               low_left = '0;
            end
         end
         r.in_high = high_alarm;
         r.in_low  = low_alarm;
         r.sticky  = sticky;
         expected_q.push_back(r);
      endfunction

      function void compare_field(string name, logic [3:0] want, logic [3:0] got);
         if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            failures++;
         end
      endfunction

      function void check_response(tad_result_type got);
         tad_result_type want;
         if (expected_q.size() == 0) begin
            $error("response with no request outstanding");
            failures++;
            return;
         end
         want = expected_q.pop_front();
         compare_field("enter_high_event", want.enter_high, got.enter_high);
         compare_field("exit_high_event", want.exit_high, got.exit_high);
         compare_field("enter_low_event", want.enter_low, got.enter_low);
         compare_field("exit_low_event", want.exit_low, got.exit_low);
         compare_field("in_high_alarm", want.in_high, got.in_high);
         compare_field("in_low_alarm", want.in_low, got.in_low);
         compare_field("sticky_events", want.sticky, got.sticky);
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_wr_en;
   logic [2:0]  csr_index;
   logic [31:0] csr_wdata;
   int          req_idle_pct = 27;
   int          rsp_idle_pct = 27;
   int          stall_cycles = 0;

   alarm_scoreboard_type sb = new();

   tad_req_if #(.SAMPLE_WIDTH(32)) req_chan ();
   tad_rsp_if                      rsp_chan ();

   threshold_alarm_with_debounce_core #(
      .SAMPLE_WIDTH  (32),
      .DEBOUNCE_WIDTH(8)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready) begin
         sb.note_request(req_chan.sample, req_chan.logging_active);
      end
   end

   always @(posedge clock) begin : rsp_monitor
      tad_result_type got;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.enter_high = rsp_chan.enter_high_event;
         got.exit_high  = rsp_chan.exit_high_event;
         got.enter_low  = rsp_chan.enter_low_event;
         got.exit_low   = rsp_chan.exit_low_event;
         got.in_high    = rsp_chan.in_high_alarm;
         got.in_low     = rsp_chan.in_low_alarm;
         got.sticky     = rsp_chan.sticky_events;
         sb.check_response(got);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles == STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic send_request(input logic [31:0] smp, input logic logging);
      while ($urandom_range(99) < req_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid          <= 1'b1;
      req_chan.sample         <= smp;
      req_chan.logging_active <= logging;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   // drop valid and wait for the next edge first so the last accepted request is already in the scoreboard
   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [31:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.write_reg(idx, val);
   endtask

   task automatic program_config(input logic [31:0] hi, input logic [31:0] lo,
                                 input logic [31:0] db, input logic [31:0] deb,
                                 input logic [31:0] mask, input logic [31:0] hen,
                                 input logic [31:0] len);
      write_csr(CSR_HIGH_LIMIT, hi);
      write_csr(CSR_LOW_LIMIT, lo);
      write_csr(CSR_DEADBAND, db);
      write_csr(CSR_DEBOUNCE_SAMPLES, deb);
      write_csr(CSR_TRIGGER_MASK, mask);
      write_csr(CSR_HIGH_ENABLED, hen);
      write_csr(CSR_LOW_ENABLED, len);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [31:0] upper_junk(logic [31:0] keep_mask);
      return ($urandom_range(1) == 1) ? ($urandom & ~keep_mask) : 32'h0;
   endfunction

   task automatic configure_phase(input int ph);
      logic [31:0] hi, lo, db, deb, mask, hen, len;
      hi = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(32'h60000)) - 32'h30000;
      lo = hi - 32'($urandom_range(32'h60000));
      case ($urandom_range(2))
         0:       db = 32'h0;
         1:       db = 32'($urandom_range(32'h8000));
         default: db = $urandom;
      endcase
      deb  = ($urandom_range(3) == 0) ? 32'($urandom_range(12)) : 32'($urandom_range(1, 4));
      mask = 32'($urandom_range(1, 15));
      hen  = ($urandom_range(3) != 0) ? 32'h1 : 32'h0;
      len  = ($urandom_range(3) != 0) ? 32'h1 : 32'h0;
      case (ph)
         0: begin
            hi = 32'h7FFFFFFF; lo = 32'h80000000; db = 32'h7FFFFFFF;
            deb = 32'd1; mask = 32'hF; hen = 32'h1; len = 32'h1;
         end
         1: begin
            hi = 32'h80000000; lo = 32'h7FFFFFFF; db = 32'h0;
            deb = 32'd0; mask = 32'hF; hen = 32'h1; len = 32'h1;
         end
         2: begin
            hi = 32'h00020000; lo = 32'hFFFE0000; db = 32'h4000;
            deb = 32'd255; mask = 32'hF; hen = 32'h1; len = 32'h1;
         end
         3: mask = 32'h0;
         default: ;
      endcase
      program_config(hi, lo, db, deb | upper_junk(32'hFF), mask | upper_junk(32'hF),
                     hen | upper_junk(32'h1), len | upper_junk(32'h1));
   endtask

   function automatic logic [31:0] pick_sample(sample_zone_type zone);
      longint h, l, d, r, v;
      h = longint'($signed(sb.high_thr));
      l = longint'($signed(sb.low_thr));
      d = longint'(sb.deadband);
      r = longint'($urandom_range(1023));
      case (zone)
         ABOVE_HIGH: v = h + d + r;
         BELOW_HIGH: v = h - d - 1 - r;
         BELOW_LOW:  v = l - d - r;
         ABOVE_LOW:  v = l + d + 1 + r;
         ON_EDGE: begin
            r = longint'($urandom_range(4)) - 2;
            case ($urandom_range(3))
               0:       v = h + d + r;
               1:       v = h - d + r;
               2:       v = l - d + r;
               default: v = l + d + r;
            endcase
         end
         default: return $urandom;
      endcase
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return v[31:0];
   endfunction

   // runs of samples in one zone, some long enough to get through debounce
   task automatic send_stream(input int count);
      int              sent;
      int              run_len;
      sample_zone_type zone;
      sent = 0;
      while (sent < count) begin
         zone = sample_zone_type'($urandom_range(5));
         if ((zone == ABOVE_HIGH || zone == BELOW_LOW) && $urandom_range(1) == 1) begin
            run_len = int'(sb.debounce_samples) + int'($urandom_range(2));
         end else if (zone == ABOVE_HIGH || zone == BELOW_LOW) begin
            run_len = int'($urandom_range(1, int'(sb.debounce_samples) + 2));
         end else begin
            run_len = int'($urandom_range(1, 6));
         end
         if (run_len < 1) run_len = 1;
         for (int k = 0; k < run_len && sent < count; k++) begin
            send_request(pick_sample(zone), $urandom_range(19) != 0);
            sent++;
         end
      end
   endtask

   initial begin
      reset                   <= 1'b1;
      req_chan.valid          <= 1'b0;
      req_chan.sample         <= '0;
      req_chan.logging_active <= 1'b0;
      csr_wr_en               <= 1'b0;
      csr_index               <= CSR_HIGH_LIMIT;
      csr_wdata               <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset config has an empty trigger mask: samples are ignored
      send_request(32'h7FFFFFFF, 1'b1);
      send_request(32'h80000000, 1'b1);
      wait_idle();
      program_config(32'h00010000, 32'hFFFF0000, 32'h00008000, 32'd2, 32'hF, 32'h1, 32'h1);
      send_request(32'h7FFFFFFF, 1'b1);
      send_request(32'h7FFFFFFF, 1'b0);
      send_request(32'h7FFFFFFF, 1'b1);
      send_request(32'h00008000, 1'b1);
      send_request(32'h00007FFF, 1'b1);
      send_request(32'h80000000, 1'b1);
      send_request(32'h80000000, 1'b1);
      send_request(32'hFFFF8000, 1'b1);
      send_request(32'hFFFF8001, 1'b1);
      send_request(32'h00018000, 1'b1);
      send_request(32'h00000000, 1'b1);
      send_request(32'h00018000, 1'b1);
      send_request(32'h00018000, 1'b1);
      send_request(32'h80000000, 1'b1);

      for (int ph = 0; ph < 12; ph++) begin
         wait_idle();
         configure_phase(ph);
         req_idle_pct = (ph == 5) ? 0 : 27;
         rsp_idle_pct = (ph == 5) ? 0 : 27;
         send_stream((ph == 2) ? 300 : ((ph == 3) ? 20 : 82));
      end

      wait_idle();
      repeat (4) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
